[hw/rtl/ltld_pkg.sv]
// Shared types, constants and fixed-point helpers for the line-to-line distance block.
package ltld_pkg;

    localparam int QW         = 32;
    localparam int FRAC_BITS  = 16;
    localparam int DIV_W      = QW + FRAC_BITS;
    localparam int DIV_LAT    = DIV_W + 2;
    localparam int SQRT_LAT   = QW + 1;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int CFG_AW     = 3;
    localparam int LATENCY    = DIV_LAT + SQRT_LAT + 11;

    typedef logic signed [QW-1:0] t_q;
    typedef logic signed [2*QW-1:0] t_qw;

    typedef enum logic [CFG_AW-1:0] {
        REG_START_X,
        REG_START_Y,
        REG_START_Z,
        REG_END_X,
        REG_END_Y,
        REG_END_Z,
        REG_THRESHOLD
    } t_reg_idx;

    // One classified item on its way from the front to the back
    typedef struct packed {
        logic     par;
        t_q       num_s;
        t_q       den_s;
        t_q       num_t;
        t_q       den_t;
        t_q [2:0] v;
        t_q [2:0] w;
    } t_job;

    // Saturate a wide signed value to the Q range
    function automatic t_q f_sat(input t_qw x);
        logic hi_zero;
        logic hi_ones;
        hi_zero = ~|x[2*QW-1:QW-1];
        hi_ones = &x[2*QW-1:QW-1];
        if (hi_zero || hi_ones) begin
            return x[QW-1:0];
        end
        return x[2*QW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    endfunction

    // Q product, floored, saturated
    function automatic t_q f_qmul(input t_q x, input t_q y);
        t_qw p;
        p = x * y;
        return f_sat(p >>> FRAC_BITS);
    endfunction

    function automatic t_q f_qadd(input t_q x, input t_q y);
        t_qw s;
        s = x;
        s = s + y;
        return f_sat(s);
    endfunction

    function automatic t_q f_qsub(input t_q x, input t_q y);
        t_qw s;
        s = x;
        s = s - y;
        return f_sat(s);
    endfunction

endpackage

[hw/rtl/ltld_div.sv]
// Pipelined restoring divider: (n * 2^FRAC_BITS) / q, truncated, saturated.
module ltld_div import ltld_pkg::*; (
    input  logic i_clk,
    input  t_q   i_num,
    input  t_q   i_den,
    output t_q   o_quo
);

    localparam logic [DIV_W-1:0] POS_LIM = DIV_W'({1'b0, {(QW-1){1'b1}}});
    localparam logic [DIV_W-1:0] NEG_LIM = POS_LIM + 1'b1;

    logic [DIV_W-1:0] r_dvd  [0:DIV_W];
    logic [DIV_W-1:0] r_quo  [0:DIV_W];
    logic [QW-1:0]    r_rem  [0:DIV_W];
    logic [QW-1:0]    r_den  [0:DIV_W];
    logic             r_neg  [0:DIV_W];
    logic             r_zero [0:DIV_W];
    t_q               r_out;

    logic [QW-1:0] n_mag;
    logic [QW-1:0] d_mag;

    assign n_mag = i_num[QW-1] ? (~i_num + 1'b1) : i_num;
    assign d_mag = i_den[QW-1] ? (~i_den + 1'b1) : i_den;

    // Operand capture in sign-magnitude form
    always_ff @(posedge i_clk) begin
        r_dvd[0]  <= DIV_W'(n_mag) << FRAC_BITS;
        r_quo[0]  <= '0;
        r_rem[0]  <= '0;
        r_den[0]  <= d_mag;
        r_neg[0]  <= i_num[QW-1] ^ i_den[QW-1];
        r_zero[0] <= (i_den == '0);
    end

    // One quotient bit per stage
    for (genvar k = 1; k <= DIV_W; k++) begin : g_step
        logic [QW:0] t;
        logic        ge;
        assign t  = {r_rem[k-1], r_dvd[k-1][DIV_W-1]};
        assign ge = (t >= {1'b0, r_den[k-1]});
        always_ff @(posedge i_clk) begin
            r_rem[k]  <= ge ? QW'(t - {1'b0, r_den[k-1]}) : t[QW-1:0];
            r_quo[k]  <= {r_quo[k-1][DIV_W-2:0], ge};
            r_dvd[k]  <= r_dvd[k-1] << 1;
            r_den[k]  <= r_den[k-1];
            r_neg[k]  <= r_neg[k-1];
            r_zero[k] <= r_zero[k-1];
        end
    end

    // Sign and saturation
    always_ff @(posedge i_clk) begin
        if (r_zero[DIV_W]) begin
            r_out <= '0;
        end else if (r_neg[DIV_W]) begin
            if (r_quo[DIV_W] > NEG_LIM) begin
                r_out <= {1'b1, {(QW-1){1'b0}}};
            end else begin
                r_out <= ~r_quo[DIV_W][QW-1:0] + 1'b1;
            end
        end else begin
            if (r_quo[DIV_W] > POS_LIM) begin
                r_out <= {1'b0, {(QW-1){1'b1}}};
            end else begin
                r_out <= r_quo[DIV_W][QW-1:0];
            end
        end
    end

    assign o_quo = r_out;

endmodule

[hw/rtl/ltld_sqrt.sv]
// Pipelined floor square root of a 2*QW bit unsigned value, one root bit per stage.
module ltld_sqrt import ltld_pkg::*; (
    input  logic            i_clk,
    input  logic [2*QW-1:0] i_val,
    output logic [QW-1:0]   o_root
);

    logic [2*QW-1:0] r_s    [0:QW];
    logic [QW+1:0]   r_rem  [0:QW];
    logic [QW-1:0]   r_root [0:QW];

    always_ff @(posedge i_clk) begin
        r_s[0]    <= i_val;
        r_rem[0]  <= '0;
        r_root[0] <= '0;
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [QW+3:0] t;
        logic [QW+3:0] trial;
        logic          ge;
        assign t     = {r_rem[k-1], r_s[k-1][2*QW-1 -: 2]};
        assign trial = {2'b00, r_root[k-1], 2'b01};
        assign ge    = (t >= trial);
        always_ff @(posedge i_clk) begin
            r_s[k]    <= r_s[k-1] << 2;
            r_rem[k]  <= ge ? (QW+2)'(t - trial) : t[QW+1:0];
            r_root[k] <= {r_root[k-1][QW-2:0], ge};
        end
    end

    assign o_root = r_root[QW];

endmodule

[hw/rtl/ltld_fifo.sv]
// Short job queue between the front and the back.
module ltld_fifo import ltld_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_data
);

    t_job               r_mem [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_AW:0]   r_cnt;
    logic               pop_ok;

    assign pop_ok  = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (FIFO_AW+1)'(i_push) - (FIFO_AW+1)'(pop_ok);
        end
    end

endmodule

[hw/rtl/ltld_front.sv]
// Front: differences, dot products, determinant and parallel classification.
module ltld_front import ltld_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_acc,
    input  t_q [2:0]    i_p0,
    input  t_q [2:0]    i_p1,
    input  t_q [2:0]    i_u,
    input  t_q [2:0]    i_rs,
    input  logic [QW-1:0] i_thr,
    output logic        o_push,
    output t_job        o_job
);

    logic [6:1] r_vld;

    t_q [2:0]  r_p0, r_p1;
    t_q [2:0]  r_v2, r_w2, r_v3, r_w3, r_v4, r_w4, r_v5, r_w5, r_v6, r_w6;
    t_q [14:0] r_pr;
    t_q        r_a, r_b, r_c, r_d, r_e;
    t_q        r_b5, r_c5, r_d5, r_e5;
    t_q        r_ac, r_bb, r_be, r_cd, r_ae, r_bd;
    t_q        r_dd, r_ns, r_nt, r_b6, r_c6, r_d6, r_e6;
    logic      par;

    // Valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[5:1], i_acc};
        end
    end

    // Stage 1: capture points
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_p0 <= i_p0;
            r_p1 <= i_p1;
        end
    end

    // Stage 2: v and w
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_v2[i] <= f_qsub(r_p1[i], r_p0[i]);
            r_w2[i] <= f_qsub(i_rs[i], r_p0[i]);
        end
    end

    // Stage 3: per-axis products
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_pr[i]      <= f_qmul(i_u[i], i_u[i]);
            r_pr[3 + i]  <= f_qmul(i_u[i], r_v2[i]);
            r_pr[6 + i]  <= f_qmul(r_v2[i], r_v2[i]);
            r_pr[9 + i]  <= f_qmul(i_u[i], r_w2[i]);
            r_pr[12 + i] <= f_qmul(r_v2[i], r_w2[i]);
        end
        r_v3 <= r_v2;
        r_w3 <= r_w2;
    end

    // Stage 4: dot products, x then y then z
    always_ff @(posedge i_clk) begin
        r_a  <= f_qadd(f_qadd(r_pr[0], r_pr[1]), r_pr[2]);
        r_b  <= f_qadd(f_qadd(r_pr[3], r_pr[4]), r_pr[5]);
        r_c  <= f_qadd(f_qadd(r_pr[6], r_pr[7]), r_pr[8]);
        r_d  <= f_qadd(f_qadd(r_pr[9], r_pr[10]), r_pr[11]);
        r_e  <= f_qadd(f_qadd(r_pr[12], r_pr[13]), r_pr[14]);
        r_v4 <= r_v3;
        r_w4 <= r_w3;
    end

    // Stage 5: cross products for D and the Cramer numerators
    always_ff @(posedge i_clk) begin
        r_ac <= f_qmul(r_a, r_c);
        r_bb <= f_qmul(r_b, r_b);
        r_be <= f_qmul(r_b, r_e);
        r_cd <= f_qmul(r_c, r_d);
        r_ae <= f_qmul(r_a, r_e);
        r_bd <= f_qmul(r_b, r_d);
        r_b5 <= r_b;
        r_c5 <= r_c;
        r_d5 <= r_d;
        r_e5 <= r_e;
        r_v5 <= r_v4;
        r_w5 <= r_w4;
    end

    // Stage 6: determinant and numerators
    always_ff @(posedge i_clk) begin
        r_dd <= f_qsub(r_ac, r_bb);
        r_ns <= f_qsub(r_be, r_cd);
        r_nt <= f_qsub(r_ae, r_bd);
        r_b6 <= r_b5;
        r_c6 <= r_c5;
        r_d6 <= r_d5;
        r_e6 <= r_e5;
        r_v6 <= r_v5;
        r_w6 <= r_w5;
    end

    // Classify: D (signed) against the unsigned threshold
    assign par = $signed({r_dd[QW-1], r_dd}) < $signed({1'b0, i_thr});

    always_comb begin
        o_job.par = par;
        o_job.v   = r_v6;
        o_job.w   = r_w6;
        if (par) begin
            o_job.num_s = '0;
            o_job.den_s = '0;
            if (r_b6 > r_c6) begin
                o_job.num_t = r_d6;
                o_job.den_t = r_b6;
            end else begin
                o_job.num_t = r_e6;
                o_job.den_t = r_c6;
            end
        end else begin
            o_job.num_s = r_ns;
            o_job.den_s = r_dd;
            o_job.num_t = r_nt;
            o_job.den_t = r_dd;
        end
    end

    assign o_push = r_vld[6];

endmodule

[hw/rtl/ltld_back.sv]
// Back: line parameters, closest-point difference, squared length and root.
module ltld_back import ltld_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_job          i_job,
    input  t_q [2:0]      i_u,
    output logic          o_valid,
    output logic [QW-1:0] o_distance,
    output logic          o_par
);

    logic     r_dv [0:DIV_LAT-1];
    logic     r_dp [0:DIV_LAT-1];
    t_q [2:0] r_dvv [0:DIV_LAT-1];
    t_q [2:0] r_dw  [0:DIV_LAT-1];

    t_q sc, tc;

    logic     r_v1, r_v2, r_v3, r_v4;
    logic     r_p1, r_p2, r_p3, r_p4;
    t_q [2:0] r_su, r_tv, r_w1;
    logic [QW-1:0]   r_mag [0:2];
    logic [2*QW-1:0] r_sq  [0:2];
    logic [2*QW-1:0] r_sum;

    logic r_sv [0:SQRT_LAT-1];
    logic r_sp [0:SQRT_LAT-1];

    ltld_div u_div_s (.i_clk(i_clk), .i_num(i_job.num_s), .i_den(i_job.den_s), .o_quo(sc));
    ltld_div u_div_t (.i_clk(i_clk), .i_num(i_job.num_t), .i_den(i_job.den_t), .o_quo(tc));

    // Item data alongside the dividers
    always_ff @(posedge i_clk) begin
        r_dp[0]  <= i_job.par;
        r_dvv[0] <= i_job.v;
        r_dw[0]  <= i_job.w;
        for (int k = 1; k < DIV_LAT; k++) begin
            r_dp[k]  <= r_dp[k-1];
            r_dvv[k] <= r_dvv[k-1];
            r_dw[k]  <= r_dw[k-1];
        end
    end

    // Valid bits for all stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_dv[k] <= 1'b0;
            end
            for (int k = 0; k < SQRT_LAT; k++) begin
                r_sv[k] <= 1'b0;
            end
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_dv[0] <= i_valid;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
            r_v1    <= r_dv[DIV_LAT-1];
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_sv[0] <= r_v4;
            for (int k = 1; k < SQRT_LAT; k++) begin
                r_sv[k] <= r_sv[k-1];
            end
        end
    end

    // P1: sc*u and tc*v
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_su[i] <= f_qmul(sc, i_u[i]);
            r_tv[i] <= f_qmul(tc, r_dvv[DIV_LAT-1][i]);
        end
        r_w1 <= r_dw[DIV_LAT-1];
        r_p1 <= r_dp[DIV_LAT-1];
    end

    // P2: dP per axis and its magnitude
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            t_q p;
            p = f_qsub(f_qadd(r_w1[i], r_su[i]), r_tv[i]);
            r_mag[i] <= p[QW-1] ? (~p + 1'b1) : p;
        end
        r_p2 <= r_p1;
    end

    // P3: squares
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_sq[i] <= r_mag[i] * r_mag[i];
        end
        r_p3 <= r_p2;
    end

    // P4: sum of squares
    always_ff @(posedge i_clk) begin
        r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        r_p4  <= r_p3;
    end

    ltld_sqrt u_sqrt (.i_clk(i_clk), .i_val(r_sum), .o_root(o_distance));

    always_ff @(posedge i_clk) begin
        r_sp[0] <= r_p4;
        for (int k = 1; k < SQRT_LAT; k++) begin
            r_sp[k] <= r_sp[k-1];
        end
    end

    assign o_valid = r_sv[SQRT_LAT-1];
    assign o_par   = r_sp[SQRT_LAT-1];

endmodule

[hw/rtl/line_to_line_distance_top.sv]
// Top level: configuration registers, credit control, front, queue and back.
//
// Closest distance between the configured ray line and the line through
// each item's two points, signed Q16.16 in, unsigned saturating Q16.16 out.
// Items: drive the six point ports and raise start; the item is taken at
// an edge where start is high and busy is low. One item per cycle is
// accepted indefinitely; busy rises only if the job queue runs out of
// credits, which the back never lets happen since it drains every cycle.
// Results: o_valid strobes for one cycle with o_distance and
// o_parallel_case, in item order, after passing the 48-step divider and
// the 32-step square root pipelines; throughput is one item per clock.
// Configuration: write index/data with i_cfg_valid; o_cfg_ready is always
// high. Indexes past the last register are ignored. Write only while idle.
// Reset (synchronous, active low) restores register defaults and empties
// the pipelines; there is no clearing pass. The receiver cannot stall.
module line_to_line_distance_top import ltld_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic signed [31:0] i_p0_x,
    input  logic signed [31:0] i_p0_y,
    input  logic signed [31:0] i_p0_z,
    input  logic signed [31:0] i_p1_x,
    input  logic signed [31:0] i_p1_y,
    input  logic signed [31:0] i_p1_z,
    output logic              o_valid,
    output logic [31:0]       o_distance,
    output logic              o_parallel_case,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_AW-1:0] i_cfg_index,
    input  logic [31:0]       i_cfg_data
);

    t_q [2:0]         r_rs;
    t_q [2:0]         r_re;
    logic [QW-1:0]    r_thr;
    t_q [2:0]         r_u;
    logic [FIFO_AW:0] r_cred;

    logic acc;
    logic push;
    logic pop;
    t_job job_in;
    t_job job_out;

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_cred == '0);
    assign acc         = start && !busy;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs  <= '0;
            r_re  <= {t_q'(65536), t_q'(0), t_q'(0)};
            r_thr <= QW'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_START_X:   r_rs[0] <= i_cfg_data;
                REG_START_Y:   r_rs[1] <= i_cfg_data;
                REG_START_Z:   r_rs[2] <= i_cfg_data;
                REG_END_X:     r_re[0] <= i_cfg_data;
                REG_END_Y:     r_re[1] <= i_cfg_data;
                REG_END_Z:     r_re[2] <= i_cfg_data;
                REG_THRESHOLD: r_thr   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Ray direction, refreshed every cycle
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_u[i] <= f_qsub(r_re[i], r_rs[i]);
        end
    end

    // Queue credits: one per slot, returned when the back takes a job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cred <= (FIFO_AW+1)'(FIFO_DEPTH);
        end else begin
            r_cred <= r_cred - (FIFO_AW+1)'(acc) + (FIFO_AW+1)'(pop);
        end
    end

    ltld_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_p0    ({i_p0_z, i_p0_y, i_p0_x}),
        .i_p1    ({i_p1_z, i_p1_y, i_p1_x}),
        .i_u     (r_u),
        .i_rs    (r_rs),
        .i_thr   (r_thr),
        .o_push  (push),
        .o_job   (job_in)
    );

    ltld_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_valid (pop),
        .o_data  (job_out)
    );

    ltld_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (pop),
        .i_job      (job_out),
        .i_u        (r_u),
        .o_valid    (o_valid),
        .o_distance (o_distance),
        .o_par      (o_parallel_case)
    );

endmodule

[hw/rtl/ltld_checker.sv]
// Port-level checks for the line-to-line distance block, bound to the top level.
module ltld_checker import ltld_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input logic              o_cfg_ready,
    input logic              i_cfg_valid
);

    // Reset empties the result pipe
    a_rst_no_result: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    // Reset returns all queue credits
    a_rst_not_busy: assert property (@(posedge i_clk) !i_rst_n |=> !busy)
        else $error("busy right after reset");

    // Every accepted beat comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("result missing at fixed latency");

    // Config channel never back-pressures once out of reset
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write stalled");

endmodule

bind line_to_line_distance_top ltld_checker u_ltld_checker (.*);
